/* rtl/assert_macros.svh */
// assertion helpers for the deque checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while in reset
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked implication, same cycle
`define DEQ_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/deq_pkg.sv */
package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int STAT_W    = 2;
  localparam int FILL_W    = 5;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } cmd_t;

endpackage

/* rtl/deq_ram.sv */
module deq_ram #(
  parameter int WIDTH = deq_pkg::DATA_W,
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/deq_ctrl.sv */
module deq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output deq_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    LOAD
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready    = (state == IDLE);
  assign out_free    = !out_valid || out_ready;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state == EXEC);
  assign cmd.load    = (state == LOAD) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.capture) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          state <= LOAD;
        end
        LOAD: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/deq_dp.sv */
module deq_dp #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  deq_pkg::cmd_t                     cmd,
  input  logic        [deq_pkg::OP_W-1:0]   opcode,
  input  logic signed [deq_pkg::DATA_W-1:0] push_value,
  output logic signed [deq_pkg::DATA_W-1:0] pop_value,
  output logic        [deq_pkg::STAT_W-1:0] status,
  output logic        [deq_pkg::FILL_W-1:0] fill_after
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = deq_pkg::DATA_W;
  localparam int FW = deq_pkg::FILL_W;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [deq_pkg::OP_W-1:0]   op_q;
  logic [DW-1:0]              val_q;
  logic [IW-1:0]              front_idx, front_idx_next;
  logic [IW-1:0]              back_idx, back_idx_next;
  logic [CW-1:0]              count, count_next;
  logic [deq_pkg::STAT_W-1:0] stat_q, stat_next;
  logic                       pop_ok_q, pop_ok_next;
  logic                       is_full, is_empty;
  logic [IW-1:0]              front_dec, front_inc, back_dec, back_inc;
  logic                       we, re;
  logic [IW-1:0]              waddr, raddr;
  logic [DW-1:0]              rdata;

  assign is_full   = (count == FULL);
  assign is_empty  = (count == '0);
  assign front_dec = (front_idx == '0) ? LAST : front_idx - 1'b1;
  assign front_inc = (front_idx == LAST) ? '0 : front_idx + 1'b1;
  assign back_dec  = (back_idx == '0) ? LAST : back_idx - 1'b1;
  assign back_inc  = (back_idx == LAST) ? '0 : back_idx + 1'b1;

  always_comb begin
    front_idx_next = front_idx;
    back_idx_next  = back_idx;
    count_next     = count;
    stat_next      = deq_pkg::ST_OK;
    pop_ok_next    = 1'b0;
    we             = 1'b0;
    re             = 1'b0;
    waddr          = back_idx;
    raddr          = front_idx;
    unique case (op_q)
      deq_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          stat_next = deq_pkg::ST_FULL;
        end else begin
          front_idx_next = front_dec;
          waddr          = front_dec;
          we             = 1'b1;
          count_next     = count + 1'b1;
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          stat_next = deq_pkg::ST_FULL;
        end else begin
          back_idx_next = back_inc;
          waddr         = back_idx;
          we            = 1'b1;
          count_next    = count + 1'b1;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (is_empty) begin
          stat_next = deq_pkg::ST_EMPTY;
        end else begin
          front_idx_next = front_inc;
          raddr          = front_idx;
          re             = 1'b1;
          pop_ok_next    = 1'b1;
          count_next     = count - 1'b1;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (is_empty) begin
          stat_next = deq_pkg::ST_EMPTY;
        end else begin
          back_idx_next = back_dec;
          raddr         = back_dec;
          re            = 1'b1;
          pop_ok_next   = 1'b1;
          count_next    = count - 1'b1;
        end
      end
      deq_pkg::OP_CLEAR: begin
        front_idx_next = '0;
        back_idx_next  = '0;
        count_next     = '0;
      end
      default: begin
      end
    endcase
  end

  deq_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we && cmd.exec),
    .waddr(waddr),
    .wdata(val_q),
    .re   (re && cmd.exec),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front_idx <= '0;
      back_idx  <= '0;
      count     <= '0;
    end else if (cmd.exec) begin
      front_idx <= front_idx_next;
      back_idx  <= back_idx_next;
      count     <= count_next;
    end
  end

  // beat payload and per-item results
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= opcode;
      val_q <= push_value;
    end
    if (cmd.exec) begin
      stat_q   <= stat_next;
      pop_ok_q <= pop_ok_next;
    end
    if (cmd.load) begin
      pop_value  <= pop_ok_q ? rdata : '0;
      status     <= stat_q;
      fill_after <= FW'(count);
    end
  end

endmodule

/* rtl/double_ended_queue.sv */
// channel   dir  handshake            payload
// in        in   in_valid/in_ready    opcode, push_value
// out       out  out_valid/out_ready  pop_value, status, fill_after
//
// one item at a time: accept, execute against the ring store, load result
// the store's registered read is issued in execute and its data taken at load
// a stalled output holds the result and blocks the next accept at load
// rst is synchronous; indexes and count clear, store contents are left as is
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic        [deq_pkg::OP_W-1:0]   opcode,
  input  logic signed [deq_pkg::DATA_W-1:0] push_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [deq_pkg::DATA_W-1:0] pop_value,
  output logic        [deq_pkg::STAT_W-1:0] status,
  output logic        [deq_pkg::FILL_W-1:0] fill_after
);

  deq_pkg::cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  deq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .opcode    (opcode),
    .push_value(push_value),
    .pop_value (pop_value),
    .status    (status),
    .fill_after(fill_after)
  );

endmodule

/* rtl/deq_chk.sv */
`include "assert_macros.svh"

module deq_chk #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic        [deq_pkg::OP_W-1:0]   opcode,
  input logic signed [deq_pkg::DATA_W-1:0] push_value,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [deq_pkg::DATA_W-1:0] pop_value,
  input logic        [deq_pkg::STAT_W-1:0] status,
  input logic        [deq_pkg::FILL_W-1:0] fill_after
);

  localparam int FW = deq_pkg::FILL_W;
  localparam logic [FW-1:0] FULL_FILL = FW'(DEPTH);

  `DEQ_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable({opcode, push_value}), "waiting input beat changed")
  `DEQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(pop_value), "stalled result beat changed")
  `DEQ_IMPLY(a_refused_zero, out_valid && status != deq_pkg::ST_OK, pop_value == '0, "refused op returned data")
  `DEQ_IMPLY(a_full_fill, out_valid && status == deq_pkg::ST_FULL, fill_after == FULL_FILL, "full refusal with wrong fill")
  `DEQ_IMPLY(a_empty_fill, out_valid && status == deq_pkg::ST_EMPTY, fill_after == '0, "empty refusal with nonzero fill")

endmodule

bind double_ended_queue deq_chk #(.DEPTH(DEPTH)) u_chk (.*);

/* tb/double_ended_queue_tb.sv */
module double_ended_queue_tb;

  localparam int DEPTH = deq_pkg::DEPTH_DEF;
  localparam int N_RANDOM = 1750;
  localparam int HOLD_LEN = 120;
  localparam int OP_W = deq_pkg::OP_W;
  localparam int DATA_W = deq_pkg::DATA_W;
  localparam int STAT_W = deq_pkg::STAT_W;
  localparam int FILL_W = deq_pkg::FILL_W;
  localparam logic [OP_W-1:0] OP_RESERVED_FIRST = deq_pkg::OP_CLEAR + 1'b1;
  localparam logic [OP_W-1:0] OP_RESERVED_LAST = '1;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    bit                       pause;
  } op_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic [STAT_W-1:0]        status;
    logic [FILL_W-1:0]        fill_after;
  } result_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] opcode = '0;
  logic signed [DATA_W-1:0] push_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] pop_value;
  logic [STAT_W-1:0] status;
  logic [FILL_W-1:0] fill_after;

  op_beat_t op_queue[$];
  result_beat_t pending_results[$];

  logic [DATA_W-1:0] ring [DEPTH];
  int front_idx = 0;
  int back_idx = 0;
  int fill_cnt = 0;

  int errors = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_empty = 0;
  int max_fill = 0;
  int hold_left = 0;
  bit hold_done = 0;

  double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .push_value(push_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pop_value(pop_value),
    .status(status),
    .fill_after(fill_after)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic result_beat_t deque_predict(logic [OP_W-1:0] op,
                                                 logic [DATA_W-1:0] value);
    result_beat_t r;
    r.pop_value = '0;
    r.status = deq_pkg::ST_OK;
    case (op)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
        if (fill_cnt >= DEPTH) begin
          r.status = deq_pkg::ST_FULL;
        end else begin
          if (op == deq_pkg::OP_PUSH_FRONT) begin
            front_idx = (front_idx + DEPTH - 1) % DEPTH;
            ring[front_idx] = value;
          end else begin
            ring[back_idx] = value;
            back_idx = (back_idx + 1) % DEPTH;
          end
          fill_cnt++;
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
        if (fill_cnt == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          if (op == deq_pkg::OP_POP_FRONT) begin
            r.pop_value = ring[front_idx];
            front_idx = (front_idx + 1) % DEPTH;
          end else begin
            back_idx = (back_idx + DEPTH - 1) % DEPTH;
            r.pop_value = ring[back_idx];
          end
          fill_cnt--;
        end
      end
      deq_pkg::OP_CLEAR: begin
        front_idx = 0;
        back_idx = 0;
        fill_cnt = 0;
      end
      default: begin
      end
    endcase
    r.fill_after = fill_cnt[FILL_W-1:0];
    return r;
  endfunction

  function automatic void add_op(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value,
                                 bit pause);
    op_beat_t b;
    b.op = op;
    b.value = value;
    b.pause = pause;
    op_queue.push_back(b);
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit quiet(int n);
    return n >= 600 && n < 900;
  endfunction

  // sender: a pause marker holds the input back until all results are in
  always @(posedge clk) begin
    result_beat_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        r = deque_predict(opcode, push_value);
        pending_results.push_back(r);
        n_accepted++;
        if (r.status == deq_pkg::ST_FULL) n_full++;
        if (r.status == deq_pkg::ST_EMPTY) n_empty++;
        if (fill_cnt > max_fill) max_fill = fill_cnt;
      end
      if (!in_valid || in_ready) begin
        if (op_queue.size() != 0 && op_queue[0].pause && pending_results.size() == 0)
          void'(op_queue.pop_front());
        if (op_queue.size() != 0 && !op_queue[0].pause &&
            (quiet(n_accepted) || $urandom_range(99) >= 6)) begin
          opcode <= op_queue[0].op;
          push_value <= op_queue[0].value;
          in_valid <= 1'b1;
          void'(op_queue.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result beat, with one long hold-off
  always @(posedge clk) begin
    result_beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: pop_value %0d status %0d fill_after %0d",
                 pop_value, status, fill_after);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (pop_value !== want.pop_value) begin
            $error("pop_value: expected %0d, got %0d", want.pop_value, pop_value);
            errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
          if (fill_after !== want.fill_after) begin
            $error("fill_after: expected %0d, got %0d", want.fill_after, fill_after);
            errors++;
          end
          n_checked++;
        end
      end
      if (!hold_done && n_checked == 250) begin
        hold_done = 1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet(n_checked) || $urandom_range(99) >= 6;
      end
    end
  end

  initial begin
    int n_gen;
    int mode;
    int run;
    int roll;
    bit is_push;
    bit paused_mid;
    logic [OP_W-1:0] op;

    n_gen = 0;
    paused_mid = 0;

    add_op(deq_pkg::OP_POP_FRONT, 32'sd5, 1'b0);
    add_op(deq_pkg::OP_POP_BACK, -32'sd1, 1'b0);
    add_op(deq_pkg::OP_PUSH_BACK, 32'sh7fff_ffff, 1'b0);
    add_op(deq_pkg::OP_POP_FRONT, '0, 1'b0);
    add_op(deq_pkg::OP_PUSH_FRONT, 32'sh8000_0000, 1'b0);
    add_op(deq_pkg::OP_POP_BACK, '1, 1'b0);
    for (int k = 0; k < DEPTH; k++) begin
      add_op(k[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
             (k == 0) ? -32'sd1 : (k == 1) ? 32'sd0 : $urandom, 1'b0);
      if (k == 3) begin
        for (int c = OP_RESERVED_FIRST; c <= OP_RESERVED_LAST; c++)
          add_op(c[OP_W-1:0], $urandom, 1'b0);
      end
    end
    add_op(deq_pkg::OP_PUSH_BACK, $urandom, 1'b0);
    add_op(deq_pkg::OP_CLEAR, $urandom, 1'b0);
    add_op(deq_pkg::OP_POP_BACK, $urandom, 1'b0);
    add_op(deq_pkg::OP_CLEAR, '0, 1'b1);

    // runs biased toward filling, draining or neither
    while (n_gen < N_RANDOM) begin
      mode = $urandom_range(2);
      run = $urandom_range(40, 10);
      for (int k = 0; k < run; k++) begin
        roll = $urandom_range(99);
        if (roll < 2) begin
          op = deq_pkg::OP_CLEAR;
        end else if (roll < 3) begin
          op = OP_W'($urandom_range(OP_RESERVED_LAST, OP_RESERVED_FIRST));
        end else begin
          roll = $urandom_range(99);
          is_push = (mode == 0) ? roll < 80 : (mode == 1) ? roll < 25 : roll < 52;
          if (is_push)
            op = $urandom_range(1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
          else
            op = $urandom_range(1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
        end
        add_op(op, rand_word(), 1'b0);
        n_gen++;
      end
      if (!paused_mid && n_gen >= N_RANDOM / 2) begin
        paused_mid = 1;
        add_op(deq_pkg::OP_CLEAR, '0, 1'b1);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (op_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("checked %0d results of %0d operations, peak fill %0d of %0d",
             n_checked, n_accepted, max_fill, DEPTH);
    $display("refused pushes on full: %0d, refused pops on empty: %0d", n_full, n_empty);
    if (errors == 0) begin
      $display("double_ended_queue: match");
    end else begin
      $display("double_ended_queue: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("double_ended_queue: mismatch");
    $finish;
  end

endmodule
